### rtl/core/ffpa_pkg.sv
// shared types, codes and defaults of the first-fit pool allocator
package ffpa_pkg;

    localparam int SEGMENTS_PER_POOL_DEF = 64;
    localparam int NUM_POOLS_DEF         = 4;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_POOL_BYTES         = 3'd0;
    localparam cfg_idx_t REG_ALIGN_LOG_NUMBER   = 3'd1;
    localparam cfg_idx_t REG_ALIGN_LOG_SYMBOLIC = 3'd2;
    localparam cfg_idx_t REG_ALIGN_LOG_TREE     = 3'd3;
    localparam cfg_idx_t REG_ALIGN_LOG_GENERAL  = 3'd4;
    localparam cfg_idx_t REG_SPLIT_OVERHEAD     = 3'd5;

    localparam logic [31:0] POOL_BYTES_RST         = 32'd262144;
    localparam logic [3:0]  ALIGN_LOG_NUMBER_RST   = 4'd5;
    localparam logic [3:0]  ALIGN_LOG_SYMBOLIC_RST = 4'd4;
    localparam logic [3:0]  ALIGN_LOG_TREE_RST     = 4'd3;
    localparam logic [3:0]  ALIGN_LOG_GENERAL_RST  = 4'd3;
    localparam logic [7:0]  SPLIT_OVERHEAD_RST     = 8'd64;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2
    } status_t;

endpackage

### rtl/core/ffpa_if.sv
// request and response channel interfaces of the pool allocator
interface ffpa_req_if import ffpa_pkg::*; ();
    logic        valid;
    logic        ready;
    cmd_t        cmd;
    logic [2:0]  obj_type;
    logic [31:0] alloc_size;
    logic [1:0]  free_pool;
    logic [31:0] free_offset;

    modport source (output valid, cmd, obj_type, alloc_size, free_pool, free_offset,
                    input ready);
    modport sink (input valid, cmd, obj_type, alloc_size, free_pool, free_offset,
                  output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic        valid;
    logic        ready;
    status_t     status;
    logic [1:0]  grant_pool;
    logic [31:0] grant_offset;
    logic [31:0] pool_free_left;

    modport source (output valid, status, grant_pool, grant_offset, pool_free_left,
                    input ready);
    modport sink (input valid, status, grant_pool, grant_offset, pool_free_left,
                  output ready);
endinterface

### rtl/core/first_fit_pool_allocator.sv
// first-fit pool allocator top level: sequencer around the segment table memory
//
// Every pool keeps an address-ordered table of segments in one shared memory
// with a single read and a single write port; all work walks that table one
// entry per cycle. An allocate scans for the first fitting segment. When that
// segment is split, the entries above it move up by one to open a slot and
// the free remainder is written into it; last the grant is written. A free
// scans for its segment and then makes a coalescing pass over the pool's
// segments. The request is taken in the idle state and the result handed over
// in the response state. After reset, and after every write of pool_bytes,
// the block rebuilds the tables and takes no request meanwhile. One request is
// worked at a time; a new one is taken while the previous result still waits
// in the output stage.
module first_fit_pool_allocator import ffpa_pkg::*; #(
    parameter int SEGMENTS_PER_POOL = SEGMENTS_PER_POOL_DEF,
    parameter int NUM_POOLS         = NUM_POOLS_DEF,
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ffpa_req_if.sink              req,
    ffpa_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int S      = SEGMENTS_PER_POOL;
    localparam int P      = NUM_POOLS;
    localparam int SEG_W  = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam int IDX_W  = $clog2(S);
    localparam int CNT_W  = $clog2(S + 1);
    localparam int PW     = (P > 1) ? $clog2(P) : 1;
    localparam int DEPTH  = P * S;
    localparam int AW     = $clog2(DEPTH);
    localparam int NEED_W = 33;

    localparam logic [31:0] SIZE_MAX = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << OFFSET_BITS) - 64'd1);
    localparam logic [SEG_W-1:0] SIZE_RST =
        SEG_W'((POOL_BYTES_RST > SIZE_MAX) ? SIZE_MAX : POOL_BYTES_RST);

    typedef struct packed {
        logic [SEG_W-1:0] start;
        logic [SEG_W-1:0] len;
        logic             free;
    } seg_t;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_SHIFT = 9'b000001000,
        S_SPLIT = 9'b000010000,
        S_GRANT = 9'b000100000,
        S_MERGE = 9'b001000000,
        S_FLUSH = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [SEG_W-1:0] size_reg, size_next;
    logic [3:0]       align_reg [4];
    logic [3:0]       align_next [4];
    logic [7:0]       ovh_reg, ovh_next;
    logic [CNT_W-1:0] cnt_reg [P];
    logic [CNT_W-1:0] cnt_next [P];
    logic [SEG_W-1:0] fbytes_reg [P];
    logic [SEG_W-1:0] fbytes_next [P];
    logic [PW-1:0]    init_ptr_reg, init_ptr_next;
    logic             dv_reg, dv_next;
    logic             acc_v_reg, acc_v_next;
    logic             out_valid_reg, out_valid_next;

    // request and working payload
    cmd_t              cmd_q_reg, cmd_q_next;
    logic [PW-1:0]     pool_q_reg, pool_q_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [31:0]       off_reg, off_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  dq_reg, dq_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    seg_t              hit_reg, hit_next;
    logic              split_reg, split_next;
    seg_t              acc_reg, acc_next;
    logic [IDX_W-1:0]  w_reg, w_next;
    status_t           res_status_reg, res_status_next;
    logic [1:0]        res_pool_reg, res_pool_next;
    logic [31:0]       res_off_reg, res_off_next;
    logic [31:0]       res_left_reg, res_left_next;
    status_t           out_status_reg, out_status_next;
    logic [1:0]        out_pool_reg, out_pool_next;
    logic [31:0]       out_off_reg, out_off_next;
    logic [31:0]       out_left_reg, out_left_next;

    // memory port signals
    logic                   ram_we, ram_re;
    logic [PW-1:0]          wr_pool;
    logic [IDX_W-1:0]       wr_idx, rd_idx;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [2*SEG_W:0]       ram_wdata, ram_rdata;
    seg_t                   rd_seg, merge_seg;

    // request decode
    logic [1:0]        a_sel;
    logic [NEED_W-1:0] align_mask, need_c;
    logic [PW-1:0]     pool_a;
    logic              free_bad;
    logic [31:0]       cfg_size;

    // datapath helpers
    logic              scan_issue, shift_issue;
    logic [IDX_W-1:0]  last_idx;
    logic [SEG_W-1:0]  rem_c, granted_c, fb_add, fb_sub;
    logic              alloc_hit, free_hit, split_c, mergeable;

    ffpa_ram #(
        .WIDTH(2 * SEG_W + 1),
        .DEPTH(DEPTH)
    ) u_seg_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ram_waddr = AW'(32'(wr_pool) * S + 32'(wr_idx));
    assign ram_raddr = AW'(32'(pool_q_reg) * S + 32'(rd_idx));
    assign rd_seg    = seg_t'(ram_rdata);

    assign a_sel      = (req.obj_type > 3'd3) ? 2'd3 : req.obj_type[1:0];
    assign align_mask = (NEED_W'(1) << align_reg[a_sel]) - NEED_W'(1);
    assign need_c     = (NEED_W'(req.alloc_size) + align_mask) & ~align_mask;
    assign pool_a     = (int'(a_sel) >= P) ? PW'(P - 1) : PW'(a_sel);
    assign free_bad   = int'(req.free_pool) >= P;
    assign cfg_size   = (cfg_wdata > SIZE_MAX) ? SIZE_MAX : cfg_wdata;

    assign scan_issue  = iss_reg < cur_cnt_reg;
    assign shift_issue = ptr_reg > hit_idx_reg;
    assign last_idx    = IDX_W'(cur_cnt_reg - CNT_W'(1));

    assign alloc_hit = rd_seg.free && (NEED_W'(rd_seg.len) >= need_reg);
    assign free_hit  = (32'(rd_seg.start) == off_reg);
    assign rem_c     = rd_seg.len - SEG_W'(need_reg);
    assign split_c   = (rem_c > SEG_W'(ovh_reg)) && (cur_cnt_reg < CNT_W'(S));
    assign granted_c = split_reg ? SEG_W'(need_reg) : hit_reg.len;
    assign fb_add    = fbytes_reg[pool_q_reg] + rd_seg.len;
    assign fb_sub    = fbytes_reg[pool_q_reg] - granted_c;

    // the freed segment is still marked busy in memory until the merge pass
    always_comb
    begin
        merge_seg = rd_seg;
        if (dq_reg == hit_idx_reg)
        begin
            merge_seg.free = 1'b1;
        end
    end

    assign mergeable = acc_reg.free && merge_seg.free &&
                       (({1'b0, acc_reg.start} + {1'b0, acc_reg.len}) ==
                        {1'b0, merge_seg.start});

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.grant_pool     = out_pool_reg;
    assign rsp.grant_offset   = out_off_reg;
    assign rsp.pool_free_left = out_left_reg;

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        ovh_next        = ovh_reg;
        cnt_next        = cnt_reg;
        fbytes_next     = fbytes_reg;
        init_ptr_next   = init_ptr_reg;
        dv_next         = 1'b0;
        acc_v_next      = acc_v_reg;
        out_valid_next  = out_valid_reg;
        cmd_q_next      = cmd_q_reg;
        pool_q_next     = pool_q_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        cur_cnt_next    = cur_cnt_reg;
        iss_next        = iss_reg;
        ptr_next        = ptr_reg;
        dq_next         = dq_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        split_next      = split_reg;
        acc_next        = acc_reg;
        w_next          = w_reg;
        res_status_next = res_status_reg;
        res_pool_next   = res_pool_reg;
        res_off_next    = res_off_reg;
        res_left_next   = res_left_reg;
        out_status_next = out_status_reg;
        out_pool_next   = out_pool_reg;
        out_off_next    = out_off_reg;
        out_left_next   = out_left_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        wr_pool         = pool_q_reg;
        wr_idx          = '0;
        rd_idx          = '0;
        ram_wdata       = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                wr_pool   = init_ptr_reg;
                ram_wdata = seg_t'{start: '0, len: size_reg, free: 1'b1};
                if (init_ptr_reg == PW'(P - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_ptr_next = init_ptr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_q_next    = req.cmd;
                    need_next     = need_c;
                    off_next      = req.free_offset;
                    iss_next      = '0;
                    res_pool_next = '0;
                    res_off_next  = '0;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        pool_q_next  = pool_a;
                        cur_cnt_next = cnt_reg[pool_a];
                        if (req.alloc_size == '0)
                        begin
                            res_status_next = ST_INVALID;
                            res_left_next   = 32'(fbytes_reg[pool_a]);
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        pool_q_next  = PW'(req.free_pool);
                        cur_cnt_next = cnt_reg[PW'(req.free_pool)];
                        if (free_bad)
                        begin
                            res_status_next = ST_INVALID;
                            res_left_next   = '0;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_issue)
                begin
                    ram_re   = 1'b1;
                    rd_idx   = iss_reg[IDX_W-1:0];
                    iss_next = iss_reg + CNT_W'(1);
                    dv_next  = 1'b1;
                    dq_next  = iss_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if ((cmd_q_reg == CMD_ALLOC) ? alloc_hit : free_hit)
                    begin
                        dv_next      = 1'b0;
                        hit_idx_next = dq_reg;
                        hit_next     = rd_seg;
                        if (cmd_q_reg == CMD_ALLOC)
                        begin
                            split_next = split_c;
                            ptr_next   = last_idx;
                            state_next = split_c ? S_SHIFT : S_GRANT;
                        end
                        else if (rd_seg.free)
                        begin
                            // double free
                            res_status_next = ST_INVALID;
                            res_left_next   = 32'(fbytes_reg[pool_q_reg]);
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            fbytes_next[pool_q_reg] = fb_add;
                            res_status_next         = ST_OK;
                            res_left_next           = 32'(fb_add);
                            iss_next                = '0;
                            acc_v_next              = 1'b0;
                            w_next                  = '0;
                            state_next              = S_MERGE;
                        end
                    end
                    else if (dq_reg == last_idx)
                    begin
                        dv_next         = 1'b0;
                        res_status_next = (cmd_q_reg == CMD_ALLOC) ? ST_NOMEM : ST_INVALID;
                        res_left_next   = 32'(fbytes_reg[pool_q_reg]);
                        state_next      = S_RESP;
                    end
                end
            end

            S_SHIFT:
            begin
                // move entries above the hit up by one, top first
                if (shift_issue)
                begin
                    ram_re   = 1'b1;
                    rd_idx   = ptr_reg;
                    ptr_next = ptr_reg - IDX_W'(1);
                    dv_next  = 1'b1;
                    dq_next  = ptr_reg;
                end
                if (dv_reg)
                begin
                    ram_we    = 1'b1;
                    wr_idx    = dq_reg + IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (!shift_issue && !dv_reg)
                begin
                    state_next = S_SPLIT;
                end
            end

            S_SPLIT:
            begin
                ram_we    = 1'b1;
                wr_idx    = hit_idx_reg + IDX_W'(1);
                ram_wdata = seg_t'{start: hit_reg.start + SEG_W'(need_reg),
                                   len:   hit_reg.len - SEG_W'(need_reg),
                                   free:  1'b1};
                cnt_next[pool_q_reg] = cnt_reg[pool_q_reg] + CNT_W'(1);
                state_next = S_GRANT;
            end

            S_GRANT:
            begin
                ram_we    = 1'b1;
                wr_idx    = hit_idx_reg;
                ram_wdata = seg_t'{start: hit_reg.start, len: granted_c, free: 1'b0};
                fbytes_next[pool_q_reg] = fb_sub;
                res_status_next = ST_OK;
                res_pool_next   = 2'(pool_q_reg);
                res_off_next    = 32'(hit_reg.start);
                res_left_next   = 32'(fb_sub);
                state_next      = S_RESP;
            end

            S_MERGE:
            begin
                // stream the table through an accumulator, writing back compacted
                if (scan_issue)
                begin
                    ram_re   = 1'b1;
                    rd_idx   = iss_reg[IDX_W-1:0];
                    iss_next = iss_reg + CNT_W'(1);
                    dv_next  = 1'b1;
                    dq_next  = iss_reg[IDX_W-1:0];
                end
                if (dv_reg)
                begin
                    if (!acc_v_reg)
                    begin
                        acc_next   = merge_seg;
                        acc_v_next = 1'b1;
                    end
                    else if (mergeable)
                    begin
                        acc_next.len = acc_reg.len + merge_seg.len;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        wr_idx    = w_reg;
                        ram_wdata = acc_reg;
                        w_next    = w_reg + IDX_W'(1);
                        acc_next  = merge_seg;
                    end
                    if (dq_reg == last_idx)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                ram_we    = 1'b1;
                wr_idx    = w_reg;
                ram_wdata = acc_reg;
                cnt_next[pool_q_reg] = CNT_W'(w_reg) + CNT_W'(1);
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pool_next   = res_pool_reg;
                    out_off_next    = res_off_reg;
                    out_left_next   = res_left_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_BYTES:
                begin
                    size_next     = SEG_W'(cfg_size);
                    init_ptr_next = '0;
                    state_next    = S_INIT;
                    for (int p = 0; p < P; p++)
                    begin
                        cnt_next[p]    = CNT_W'(1);
                        fbytes_next[p] = SEG_W'(cfg_size);
                    end
                end
                REG_ALIGN_LOG_NUMBER:   align_next[0] = cfg_wdata[3:0];
                REG_ALIGN_LOG_SYMBOLIC: align_next[1] = cfg_wdata[3:0];
                REG_ALIGN_LOG_TREE:     align_next[2] = cfg_wdata[3:0];
                REG_ALIGN_LOG_GENERAL:  align_next[3] = cfg_wdata[3:0];
                REG_SPLIT_OVERHEAD:     ovh_next      = cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            size_reg      <= SIZE_RST;
            align_reg[0]  <= ALIGN_LOG_NUMBER_RST;
            align_reg[1]  <= ALIGN_LOG_SYMBOLIC_RST;
            align_reg[2]  <= ALIGN_LOG_TREE_RST;
            align_reg[3]  <= ALIGN_LOG_GENERAL_RST;
            ovh_reg       <= SPLIT_OVERHEAD_RST;
            for (int p = 0; p < P; p++)
            begin
                cnt_reg[p]    <= CNT_W'(1);
                fbytes_reg[p] <= SIZE_RST;
            end
            init_ptr_reg  <= '0;
            dv_reg        <= 1'b0;
            acc_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            align_reg     <= align_next;
            ovh_reg       <= ovh_next;
            cnt_reg       <= cnt_next;
            fbytes_reg    <= fbytes_next;
            init_ptr_reg  <= init_ptr_next;
            dv_reg        <= dv_next;
            acc_v_reg     <= acc_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_q_reg      <= cmd_q_next;
        pool_q_reg     <= pool_q_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        cur_cnt_reg    <= cur_cnt_next;
        iss_reg        <= iss_next;
        ptr_reg        <= ptr_next;
        dq_reg         <= dq_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        split_reg      <= split_next;
        acc_reg        <= acc_next;
        w_reg          <= w_next;
        res_status_reg <= res_status_next;
        res_pool_reg   <= res_pool_next;
        res_off_reg    <= res_off_next;
        res_left_reg   <= res_left_next;
        out_status_reg <= out_status_next;
        out_pool_reg   <= out_pool_next;
        out_off_reg    <= out_off_next;
        out_left_reg   <= out_left_next;
    end

`ifndef ASSERT_OFF
    // a walked table always holds between one and a full pool of segments
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cur_cnt_reg != '0 && cur_cnt_reg <= CNT_W'(S))
        else $error("segment count out of range during scan");

    // shifting only moves entries that lie above the split segment
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && dv_reg) |-> dq_reg > hit_idx_reg)
        else $error("shift touches an entry at or below the split segment");

    // a split never runs on a full table
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> cur_cnt_reg < CNT_W'(S))
        else $error("split on a full segment table");

    // compaction writes stay behind the read stream
    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE && ram_we) |-> w_reg < dq_reg)
        else $error("merge write overtakes merge read");

    // a waiting result is never overwritten
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_valid_reg && !rsp.ready) |=> state_reg == S_RESP)
        else $error("result loaded over an untaken transaction");
`endif

endmodule

### rtl/core/ffpa_ram.sv
// generic simple dual-port ram with registered read
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### tb/tb_first_fit_pool_allocator.sv
// testbench of the first-fit pool allocator: random requests checked against a segment-table predictor
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator;
    import ffpa_pkg::*;

    localparam int SEGS = SEGMENTS_PER_POOL_DEF;
    localparam int POOLS = NUM_POOLS_DEF;
    localparam int DRAIN_CYCLES = 2 * SEGS + 40;

    typedef struct {
        cmd_t        cmd;
        logic [2:0]  obj_type;
        logic [31:0] alloc_size;
        logic [1:0]  free_pool;
        logic [31:0] free_offset;
    } request_t;

    typedef struct {
        status_t     status;
        logic [1:0]  grant_pool;
        logic [31:0] grant_offset;
        logic [31:0] pool_free_left;
    } response_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ffpa_req_if req ();
    ffpa_rsp_if rsp ();

    first_fit_pool_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    logic [31:0] seg_start_m [POOLS][SEGS];
    logic [31:0] seg_len_m [POOLS][SEGS];
    bit          seg_free_m [POOLS][SEGS];
    int          seg_cnt_m [POOLS];
    logic [31:0] free_bytes_m [POOLS];
    logic [31:0] pool_bytes_m;
    logic [3:0]  align_m [4];
    logic [7:0]  overhead_m;

    request_t  pending_reqs [$];
    response_t expected_rsps [$];
    logic [33:0] live_segs [$];
    logic [33:0] released_segs [$];
    request_t  cur_req;
    int send_idle;
    int recv_idle;
    int errors;
    int n_checked;
    int n_nomem;
    int n_invalid;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void rebuild_pools();
        for (int p = 0; p < POOLS; p++)
        begin
            for (int i = 0; i < SEGS; i++)
            begin
                seg_start_m[p][i] = '0;
                seg_len_m[p][i] = '0;
                seg_free_m[p][i] = 1'b1;
            end
            seg_len_m[p][0] = pool_bytes_m;
            seg_cnt_m[p] = 1;
            free_bytes_m[p] = pool_bytes_m;
        end
        live_segs.delete();
        released_segs.delete();
    endfunction

    function automatic void merge_free_runs(int p);
        int i;
        i = 0;
        while (i + 1 < seg_cnt_m[p])
        begin
            if (seg_free_m[p][i] && seg_free_m[p][i+1] &&
                ({1'b0, seg_start_m[p][i]} + {1'b0, seg_len_m[p][i]}) ==
                {1'b0, seg_start_m[p][i+1]})
            begin
                seg_len_m[p][i] = seg_len_m[p][i] + seg_len_m[p][i+1];
                for (int k = i + 1; k + 1 < seg_cnt_m[p]; k++)
                begin
                    seg_start_m[p][k] = seg_start_m[p][k+1];
                    seg_len_m[p][k] = seg_len_m[p][k+1];
                    seg_free_m[p][k] = seg_free_m[p][k+1];
                end
                seg_cnt_m[p]--;
            end
            else
                i++;
        end
    endfunction

    function automatic response_t serve_request(request_t r);
        response_t o;
        int p;
        int i;
        int cnt;
        logic [63:0] mask;
        logic [63:0] need;
        logic [63:0] rem;
        o.status = ST_OK;
        o.grant_pool = '0;
        o.grant_offset = '0;
        o.pool_free_left = '0;
        if (r.cmd == CMD_ALLOC)
        begin
            p = (r.obj_type > 3) ? 3 : r.obj_type;
            if (r.alloc_size == 0)
                o.status = ST_INVALID;
            else
            begin
                mask = (64'd1 << align_m[p]) - 1;
                need = ({32'd0, r.alloc_size} + mask) & ~mask;
                cnt = seg_cnt_m[p];
                for (i = 0; i < cnt; i++)
                    if (seg_free_m[p][i] && {32'd0, seg_len_m[p][i]} >= need)
                        break;
                if (i == cnt)
                    o.status = ST_NOMEM;
                else
                begin
                    rem = {32'd0, seg_len_m[p][i]} - need;
                    if (rem > overhead_m && cnt < SEGS)
                    begin
                        for (int k = cnt; k > i + 1; k--)
                        begin
                            seg_start_m[p][k] = seg_start_m[p][k-1];
                            seg_len_m[p][k] = seg_len_m[p][k-1];
                            seg_free_m[p][k] = seg_free_m[p][k-1];
                        end
                        seg_start_m[p][i+1] = seg_start_m[p][i] + need[31:0];
                        seg_len_m[p][i+1] = rem[31:0];
                        seg_free_m[p][i+1] = 1'b1;
                        seg_len_m[p][i] = need[31:0];
                        seg_cnt_m[p] = cnt + 1;
                    end
                    seg_free_m[p][i] = 1'b0;
                    free_bytes_m[p] = free_bytes_m[p] - seg_len_m[p][i];
                    o.grant_pool = p[1:0];
                    o.grant_offset = seg_start_m[p][i];
                    live_segs.push_back({p[1:0], seg_start_m[p][i]});
                end
            end
            o.pool_free_left = free_bytes_m[p];
        end
        else
        begin
            p = r.free_pool;
            cnt = seg_cnt_m[p];
            for (i = 0; i < cnt; i++)
                if (seg_start_m[p][i] == r.free_offset)
                    break;
            if (i == cnt || seg_free_m[p][i])
                o.status = ST_INVALID;
            else
            begin
                seg_free_m[p][i] = 1'b1;
                free_bytes_m[p] = free_bytes_m[p] + seg_len_m[p][i];
                merge_free_runs(p);
            end
            o.pool_free_left = free_bytes_m[p];
        end
        return o;
    endfunction

    function automatic request_t alloc_req(logic [2:0] t, logic [31:0] s);
        request_t r;
        r.cmd = CMD_ALLOC;
        r.obj_type = t;
        r.alloc_size = s;
        r.free_pool = 2'($urandom_range(3));
        r.free_offset = $urandom;
        return r;
    endfunction

    function automatic request_t free_req(logic [1:0] p, logic [31:0] off);
        request_t r;
        r.cmd = CMD_FREE;
        r.obj_type = 3'($urandom_range(7));
        r.alloc_size = $urandom;
        r.free_pool = p;
        r.free_offset = off;
        return r;
    endfunction

    function automatic request_t random_req(bit wide);
        int roll;
        int idx;
        logic [33:0] seg;
        logic [31:0] sz;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            case ($urandom_range(9))
                0: sz = $urandom;
                1: sz = wide ? $urandom : $urandom_range(65536, 1);
                2: sz = $urandom_range(2);
                3: sz = 32'hFFFF_FFFF - $urandom_range(40000);
                default: sz = wide ? $urandom_range(32'h0800_0000, 1) : $urandom_range(4096, 1);
            endcase
            if ($urandom_range(49) == 0)
                sz = '0;
            return alloc_req(3'($urandom_range(7)), sz);
        end
        else if (roll < 88 && live_segs.size() > 0)
        begin
            idx = $urandom_range(live_segs.size() - 1);
            seg = live_segs[idx];
            live_segs.delete(idx);
            released_segs.push_back(seg);
            if (released_segs.size() > 32)
                void'(released_segs.pop_front());
            return free_req(seg[33:32], seg[31:0]);
        end
        else if (roll < 94 && released_segs.size() > 0)
        begin
            // double free, or a start that merged away
            seg = released_segs[$urandom_range(released_segs.size() - 1)];
            return free_req(seg[33:32], seg[31:0]);
        end
        return free_req(2'($urandom_range(3)), $urandom);
    endfunction

    // driver: presents pending requests, predicts at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.cmd <= CMD_ALLOC;
            req.obj_type <= '0;
            req.alloc_size <= '0;
            req.free_pool <= '0;
            req.free_offset <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_rsps.push_back(serve_request(cur_req));
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_req = pending_reqs.pop_front();
                    req.valid <= 1'b1;
                    req.cmd <= cur_req.cmd;
                    req.obj_type <= cur_req.obj_type;
                    req.alloc_size <= cur_req.alloc_size;
                    req.free_pool <= cur_req.free_pool;
                    req.free_offset <= cur_req.free_offset;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor: checks every response transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        response_t e;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response status %0d offset %h", $time,
                             rsp.status, rsp.grant_offset);
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    n_checked++;
                    if (e.status == ST_NOMEM)
                        n_nomem++;
                    if (e.status == ST_INVALID)
                        n_invalid++;
                    if (rsp.status !== e.status || rsp.grant_pool !== e.grant_pool ||
                        rsp.grant_offset !== e.grant_offset ||
                        rsp.pool_free_left !== e.pool_free_left)
                    begin
                        errors++;
                        $display("%0t: mismatch expected st %0d pool %0d off %h left %h",
                                 $time, e.status, e.grant_pool, e.grant_offset,
                                 e.pool_free_left);
                        $display("%0t:          actual   st %0d pool %0d off %h left %h",
                                 $time, rsp.status, rsp.grant_pool, rsp.grant_offset,
                                 rsp.pool_free_left);
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_POOL_BYTES:
            begin
                pool_bytes_m = v;
                rebuild_pools();
            end
            REG_ALIGN_LOG_NUMBER:   align_m[0] = v[3:0];
            REG_ALIGN_LOG_SYMBOLIC: align_m[1] = v[3:0];
            REG_ALIGN_LOG_TREE:     align_m[2] = v[3:0];
            REG_ALIGN_LOG_GENERAL:  align_m[3] = v[3:0];
            REG_SPLIT_OVERHEAD:     overhead_m = v[7:0];
            default: ;
        endcase
    endtask

    task automatic push_when_room(request_t r);
        while (pending_reqs.size() >= 2)
            @(posedge clk);
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        logic [31:0] psize;
        logic [3:0] al [4];
        logic [7:0] ovh;
        errors = 0;
        n_checked = 0;
        n_nomem = 0;
        n_invalid = 0;
        send_idle = 8;
        recv_idle = 68;
        cfg_we = 1'b0;
        cfg_index = REG_POOL_BYTES;
        cfg_wdata = '0;
        pool_bytes_m = POOL_BYTES_RST;
        align_m[0] = ALIGN_LOG_NUMBER_RST;
        align_m[1] = ALIGN_LOG_SYMBOLIC_RST;
        align_m[2] = ALIGN_LOG_TREE_RST;
        align_m[3] = ALIGN_LOG_GENERAL_RST;
        overhead_m = SPLIT_OVERHEAD_RST;
        rebuild_pools();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every type, zero size, double and unknown frees
        for (int t = 0; t < 8; t++)
            push_when_room(alloc_req(3'(t), 32'(t + 1)));
        push_when_room(alloc_req(3'd0, 32'd0));
        push_when_room(alloc_req(3'd1, 32'hFFFF_FFFF));
        push_when_room(alloc_req(3'd7, 32'hFFFF_FFF0));
        push_when_room(alloc_req(3'd2, POOL_BYTES_RST));
        push_when_room(free_req(2'd0, 32'd0));
        push_when_room(free_req(2'd0, 32'd0));
        push_when_room(free_req(2'd1, 32'd12345));
        push_when_room(free_req(2'd3, 32'hFFFF_FFFF));
        push_when_room(free_req(2'd2, 32'd0));
        push_when_room(alloc_req(3'd2, POOL_BYTES_RST));
        push_when_room(alloc_req(3'd2, 32'd1));
        push_when_room(free_req(2'd3, 32'd0));
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle = (ph < 2) ? 8 : (ph < 4) ? 68 : 0;
            recv_idle = (ph < 2) ? 68 : (ph < 4) ? 8 : 0;
            case (ph)
                0: begin psize = 32'hFFFF_FFFF; ovh = 8'd0; end
                1: begin psize = 32'd262144; ovh = 8'd255; end
                2: begin psize = 32'h0001_2345; ovh = 8'd17; end
                3: begin psize = 32'h8000_0000; ovh = 8'd200; end
                4: begin psize = 32'd262144; ovh = 8'd0; end
                default: begin psize = $urandom_range(32'h0010_0000, 32'h0004_0000);
                    ovh = 8'($urandom); end
            endcase
            for (int k = 0; k < 4; k++)
            begin
                if (ph == 0)
                    al[k] = 4'd0;
                else if (ph == 1)
                    al[k] = 4'd12;
                else if (ph == 3)
                    al[k] = 4'(15 - k);
                else
                    al[k] = 4'($urandom_range(12));
            end
            cfg_write(REG_POOL_BYTES, psize);
            cfg_write(REG_ALIGN_LOG_NUMBER, {28'd0, al[0]});
            cfg_write(REG_ALIGN_LOG_SYMBOLIC, {28'd0, al[1]});
            cfg_write(REG_ALIGN_LOG_TREE, {28'd0, al[2]});
            cfg_write(REG_ALIGN_LOG_GENERAL, {28'd0, al[3]});
            cfg_write(REG_SPLIT_OVERHEAD, {24'd0, ovh});
            @(posedge clk);
            cfg_we <= 1'b0;
            for (int n = 0; n < 290; n++)
                push_when_room(random_req(psize > 32'h0100_0000));
            wait_idle();
        end

        $display("checked %0d responses over six register settings and three idle patterns",
                 n_checked);
        $display("%0d of them out of memory, %0d rejected", n_nomem, n_invalid);
        if (errors == 0)
            $display("tb_first_fit_pool_allocator OK");
        else
            $display("tb_first_fit_pool_allocator NOT OK");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_first_fit_pool_allocator NOT OK");
        $finish;
    end

endmodule
